// ----- hdl/tfrb_pkg.sv -----
// Package for the terminated frame receive buffer.
// Holds the item structs, the command, status and byte codes, and the index unit control.
// No dependencies.
`default_nettype none
package tfrb_pkg;

	localparam logic       CMD_BYTE = 1'b0;
	localparam logic       CMD_READ = 1'b1;

	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_BYTE    = 2'd1;
	localparam logic [1:0] ST_DISCARD = 2'd2;

	localparam logic [7:0] CR_BYTE   = 8'd13;
	localparam logic [7:0] LF_BYTE   = 8'd10;
	localparam logic [7:0] TERM_RST  = 8'd10;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data_byte;
		logic       last;
	} rsp_t;

	// commands to the shared index counter
	typedef struct packed {
		logic clear;
		logic step;
	} idx_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/terminated_frame_receive_buffer_top.sv -----
// Terminated frame receive buffer, top level: sequencer, marks and output register.
// Depends on tfrb_pkg, tfrb_store and tfrb_index_unit.
//
// Received bytes (command 0) are taken one per cycle while no read is in progress
// and appended to the frame store while it has room; the terminator byte is not
// stored and marks the frame complete; any byte that arrives while the store is full
// sets the overflow mark. A read request (command 1) yields a response: status 2
// (discard, store flushed) after an overflow, status 0 (nothing ready) when no frame
// is marked, and otherwise the stored bytes, CR and LF, with last on LF, after which
// the store is flushed. Timing: a read first decides what to answer and then streams
// one transfer per cycle from the store's registered read port while the sink does
// not stall. The request channel is stalled for the whole read; a result waiting in
// the output register holds off the next read step. The terminator byte (term_q) is
// written through cfg_we/cfg_data and resets to 10.
`default_nettype none
module terminated_frame_receive_buffer_top
	import tfrb_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RESP = 5'b00010,
		S_BYTE = 5'b00100,
		S_CR   = 5'b01000,
		S_LF   = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	logic [7:0]    term_q;
	logic [CW-1:0] fill_q;
	logic          complete_q;
	logic          overflow_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// sequencer outputs
	logic          load;
	rsp_t          load_data;
	logic          flush;
	logic          rd_en;
	logic [CW-1:0] rd_idx;
	idx_ctrl_t     ictl;

	logic          req_xfer;
	logic          has_room;
	logic          is_term;
	logic          wr_en;
	logic          slot_free;
	logic [7:0]    rd_data;
	logic [CW-1:0] idx;
	logic [CW-1:0] idx_next;
	logic          at_end;

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign has_room  = (fill_q != CW'(CAPACITY));
	assign is_term   = (req.rx_byte == term_q);
	assign wr_en     = req_xfer && (req.command == CMD_BYTE) && has_room && !is_term;
	// output register can take a new result this cycle
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tfrb_store #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (fill_q[AW-1:0]),
		.wdata  (req.rx_byte),
		.re     (rd_en),
		.raddr  (rd_idx[AW-1:0]),
		.rdata_q(rd_data)
	);

	tfrb_index_unit #(
		.CW(CW)
	) u_index (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ictl),
		.fill    (fill_q),
		.idx     (idx),
		.idx_next(idx_next),
		.at_end  (at_end)
	);

	// sequencer
	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		load_data  = '{status: ST_NONE, data_byte: 8'd0, last: 1'b1};
		flush      = 1'b0;
		rd_en      = 1'b0;
		rd_idx     = idx_next;
		ictl       = '{clear: 1'b0, step: 1'b0};
		case (state_q)
			S_IDLE: begin
				if (req_xfer && (req.command == CMD_READ)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (overflow_q) begin
					// discard wins over a marked frame
					if (slot_free) begin
						load      = 1'b1;
						load_data = '{status: ST_DISCARD, data_byte: 8'd0, last: 1'b1};
						flush     = 1'b1;
						state_d   = S_IDLE;
					end
				end else if (complete_q) begin
					if (fill_q == '0) begin
						state_d = S_CR;
					end else begin
						rd_en      = 1'b1;
						rd_idx     = '0;
						ictl.clear = 1'b1;
						state_d    = S_BYTE;
					end
				end else if (slot_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_BYTE: begin
				// rd_data holds the byte at idx
				if (slot_free) begin
					load      = 1'b1;
					load_data = '{status: ST_BYTE, data_byte: rd_data, last: 1'b0};
					if (at_end) begin
						state_d = S_CR;
					end else begin
						rd_en     = 1'b1;
						ictl.step = 1'b1;
					end
				end
			end
			S_CR: begin
				if (slot_free) begin
					load      = 1'b1;
					load_data = '{status: ST_BYTE, data_byte: CR_BYTE, last: 1'b0};
					state_d   = S_LF;
				end
			end
			S_LF: begin
				if (slot_free) begin
					load      = 1'b1;
					load_data = '{status: ST_BYTE, data_byte: LF_BYTE, last: 1'b1};
					flush     = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			term_q     <= TERM_RST;
			fill_q     <= '0;
			complete_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				term_q <= cfg_data;
			end
			if (flush) begin
				fill_q     <= '0;
				complete_q <= 1'b0;
				overflow_q <= 1'b0;
			end else if (req_xfer && (req.command == CMD_BYTE)) begin
				if (!has_room) begin
					overflow_q <= 1'b1;
				end else if (is_term) begin
					complete_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= load_data;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_BYTE) |-> rsp.last)
		else $error("non-frame result without last");

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BYTE) |-> (idx < fill_q) && complete_q)
		else $error("read index outside stored frame");

	a_flush_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && load_data.last && (load_data.status != ST_NONE) |=> (fill_q == '0))
		else $error("store not flushed after response");

endmodule
`default_nettype wire

// ----- hdl/tfrb_store.sv -----
// Frame byte store: one write port, one read port with registered read data.
// Depends on nothing; sized by the top level.
`default_nettype none
module tfrb_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata_q
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/tfrb_index_unit.sv -----
// Shared read index: one incrementer and one end-of-frame compare against the fill count.
// Uses tfrb_pkg for the control struct.
`default_nettype none
module tfrb_index_unit
	import tfrb_pkg::*;
#(
	parameter int CW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire idx_ctrl_t     ctrl,
	input  wire logic [CW-1:0] fill,
	output logic      [CW-1:0] idx,
	output logic      [CW-1:0] idx_next,
	output logic               at_end
);

	logic [CW-1:0] idx_q;

	assign idx      = idx_q;
	assign idx_next = idx_q + CW'(1);
	assign at_end   = (idx_next == fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctrl.clear) begin
			idx_q <= '0;
		end else if (ctrl.step) begin
			idx_q <= idx_next;
		end
	end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for terminated_frame_receive_buffer_top: sends byte and read transfers, tracks the
// frame store in a behavioral model and checks every response transfer in order.
// Depends on tfrb_pkg and the RTL of the frame receive buffer.
module testbench;
	import tfrb_pkg::*;

	localparam int CAPACITY = 32;
	localparam int HOLD_CYCLES = 150;   // long sink hold-off, long enough to back up the input
	localparam int SETTLE_CYCLES = 8;   // idle time after the last response; bytes give no response
	localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
	localparam int MAX_REPORTS = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'h00;

	// Frame model state, updated as each request transfer is accepted.
	logic [7:0]  frame_copy [CAPACITY];
	int unsigned frame_fill = 0;
	bit          frame_done = 1'b0;
	bit          ovf_flag = 1'b0;
	logic [7:0]  term_byte = TERM_RST;
	rsp_t        want_rsp [$];

	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_reqs = 0;      // bumped by a test to ask for a sink hold-off
	int unsigned hold_done = 0;
	int unsigned hold_cnt = 0;
	int unsigned quiet_cycles = 0;

	always #5 clk = ~clk;

	terminated_frame_receive_buffer_top #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Update the frame model for one accepted request and queue the responses it causes.
	function automatic void track_item(logic cmd, logic [7:0] b);
		int unsigned i;
		if (cmd == CMD_BYTE) begin
			if (frame_fill < CAPACITY) begin
				// terminator marks the frame but is never stored
				if (b == term_byte) begin
					frame_done = 1'b1;
				end else begin
					frame_copy[frame_fill] = b;
					frame_fill++;
				end
			end else begin
				// store full: any byte, terminator included, is dropped and flags overflow
				ovf_flag = 1'b1;
			end
		end else if (ovf_flag) begin
			// discard wins even when a frame is marked too
			want_rsp.push_back({ST_DISCARD, 8'h00, 1'b1});
			frame_fill = 0;
			frame_done = 1'b0;
			ovf_flag = 1'b0;
		end else if (frame_done) begin
			for (i = 0; i < frame_fill; i++) begin
				want_rsp.push_back({ST_BYTE, frame_copy[i], 1'b0});
			end
			want_rsp.push_back({ST_BYTE, CR_BYTE, 1'b0});
			want_rsp.push_back({ST_BYTE, LF_BYTE, 1'b1});
			frame_fill = 0;
			frame_done = 1'b0;
		end else begin
			want_rsp.push_back({ST_NONE, 8'h00, 1'b1});
		end
	endfunction

	// Random frame byte that is never the current terminator.
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == term_byte) begin
			b = b ^ 8'h01;
		end
		return b;
	endfunction

	// Offer one request; returns at the rising edge where it transfers.
	// Valid stays high until the next falling edge, where the next call or
	// release_req takes over.
	task automatic send_req(logic cmd, logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req.command <= cmd;
		req.rx_byte <= b;
		do begin
			@(posedge clk);
		end while (req_stall);
		track_item(cmd, b);
		items_sent++;
	endtask

	task automatic send_read();
		send_req(CMD_READ, 8'($urandom_range(0, 255)));
	endtask

	// len body bytes, optional terminator, trailing bytes after the mark, optional read.
	task automatic send_frame(int unsigned len, int unsigned trailing, bit terminate, bit ask);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			send_req(CMD_BYTE, body_byte());
		end
		if (terminate) begin
			send_req(CMD_BYTE, term_byte);
		end
		for (i = 0; i < trailing; i++) begin
			send_req(CMD_BYTE, body_byte());
		end
		if (ask) begin
			send_read();
		end
	endtask

	task automatic release_req();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic wait_responses();
		while (want_rsp.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// End of a phase: stop offering, let every response arrive, let the block settle.
	task automatic finish_phase();
		release_req();
		wait_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic set_terminator(logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		term_byte = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Terminator then read: leaves the store empty whatever state it was in.
	task automatic flush_frame();
		send_req(CMD_BYTE, term_byte);
		send_read();
	endtask

	// Runs with the reset terminator (LF).
	task automatic test_directed();
		send_read();                      // nothing ready
		send_req(CMD_BYTE, term_byte);    // empty frame
		send_read();                      // CR, LF only
		send_req(CMD_BYTE, 8'h00);
		send_req(CMD_BYTE, 8'hFF);
		send_req(CMD_BYTE, CR_BYTE);      // CR value is stored like any byte
		send_req(CMD_BYTE, term_byte);
		send_req(CMD_BYTE, 8'h55);        // appended after the frame mark
		send_req(CMD_READ, 8'hFF);        // rx_byte ignored on reads
		send_req(CMD_BYTE, 8'hAA);
		send_req(CMD_READ, 8'h00);        // unterminated: nothing ready, byte kept
		send_req(CMD_BYTE, term_byte);
		send_read();                      // AA, CR, LF
		send_read();
		finish_phase();
	endtask

	// Cases that need a full store.
	task automatic test_full_store();
		// largest response: 31 bytes, mark, one more byte fills the store
		flush_frame();
		send_frame(CAPACITY - 1, 1, 1, 1);
		// terminator while full: overflow, frame mark untouched
		flush_frame();
		send_frame(CAPACITY, 0, 1, 1);
		// frame marked, then overflow: discard wins and both marks clear
		flush_frame();
		send_frame(3, CAPACITY - 2, 1, 1);
		send_read();
		finish_phase();
	endtask

	// Mostly well-formed frames with random content, plus noise and broken frames.
	task automatic test_random(int unsigned n);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, CAPACITY - 1)
					: $urandom_range(0, 8),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, 1'b1, 1'b1);
			end else if (pick < 70) begin
				send_read();
			end else if (pick < 80) begin
				send_frame($urandom_range(1, 4), 0, 1'b0, 1'b1);
			end else if (pick < 96) begin
				send_req(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0) ? term_byte
					: 8'($urandom_range(0, 255)));
			end else begin
				// overrun the store, maybe terminate, then read
				while (frame_fill < CAPACITY) begin
					send_req(CMD_BYTE, body_byte());
				end
				send_frame(0, $urandom_range(1, 2), 1'($urandom_range(0, 1)), 1'b1);
			end
		end
		finish_phase();
	endtask

	// Sink holds off while the source keeps offering: the output backs up and the
	// request side must stall through the read.
	task automatic test_backpressure();
		hold_reqs++;
		send_frame(5, 0, 1'b1, 1'b1);
		send_frame(3, 1, 1'b1, 1'b1);
		send_read();
		send_frame(2, 0, 1'b0, 1'b0);
		send_frame(0, 0, 1'b1, 1'b1);
		finish_phase();
	endtask

	// Source pauses until every response is back, then resumes.
	task automatic test_drain_pause();
		send_frame(4, 0, 1'b1, 1'b1);
		release_req();
		wait_responses();
		send_read();
		send_frame(6, 0, 1'b1, 1'b1);
		finish_phase();
	endtask

	// Sink side: random stalls, or a counted hold-off when a test asks for one.
	always @(negedge clk) begin
		if (hold_done != hold_reqs) begin
			hold_done = hold_reqs;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt != 0) begin
			hold_cnt = hold_cnt - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Response checker: each transfer against the oldest queued response.
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (want_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: unexpected response: status %0d data %02h last %0b",
						$realtime, rsp.status, rsp.data_byte, rsp.last);
				end
			end else begin
				want = want_rsp.pop_front();
				if (rsp.status !== want.status || rsp.data_byte !== want.data_byte
						|| rsp.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: response mismatch: want status %0d data %02h last %0b",
							$realtime, want.status, want.data_byte, want.last);
						$display("    got status %0d data %02h last %0b",
							rsp.status, rsp.data_byte, rsp.last);
					end
				end
			end
		end
	end

	// Watchdog: too long without a transfer on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles = quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// source idles more rarely than the sink
		send_idle_pct = 27;
		recv_idle_pct = 62;
		test_directed();
		set_terminator(8'h00);
		test_random(25);

		// roles swapped
		send_idle_pct = 62;
		recv_idle_pct = 27;
		set_terminator(8'hFF);
		test_random(20);

		// no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_terminator(8'($urandom_range(0, 255)));
		test_full_store();
		test_random(15);
		test_backpressure();
		set_terminator(CR_BYTE);
		test_drain_pause();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && want_rsp.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
